/* sv/srdc_pkg.sv */
// srdc_pkg: widths, register indexes, reset values and the clamp helper
// for the stick radial deadzone cursor mover
// no dependencies
`default_nettype none

package srdc_pkg;

	// field widths
	localparam int TickW    = 32;
	localparam int AxisW    = 16;
	localparam int CoordW   = 12;
	localparam int DzW      = 16;
	localparam int SpeedW   = 12;
	localparam int SizeW    = 13;
	localparam int CfgDataW = 16;
	localparam int CfgIdxW  = 3;

	// packed stream words
	localparam int InW  = 88;
	localparam int OutW = 24;

	// datapath widths
	localparam int MagW   = 16;          // |axis| and integer magnitude
	localparam int SqW    = 32;          // sum of squares, root registers
	localparam int NW     = 17;          // normalised magnitude, Q1.16
	localparam int QW     = 12;          // per-axis step in pixels
	localparam int DivW   = 26;          // magnitude times 1000
	localparam int SumW   = CoordW + 2;  // signed cursor plus step
	localparam int CntW   = 5;

	// phase lengths in cycles
	localparam int SquareLen = 16;
	localparam int RootLen   = 16;
	localparam int NDivLen   = 17;
	localparam int MulLen    = 17;
	localparam int QDivLen   = 12;

	localparam int MaxStepMsDef = 50;

	localparam logic [NW-1:0]    NOne     = NW'(65536);
	localparam logic [SizeW-1:0] CoordMax = SizeW'((1 << CoordW) - 1);

	// reset values of the registers
	localparam logic [DzW-1:0]    DzRst     = DzW'(11796);
	localparam logic [SpeedW-1:0] SpeedRst  = SpeedW'(780);
	localparam logic [SizeW-1:0]  WidthRst  = SizeW'(960);
	localparam logic [SizeW-1:0]  HeightRst = SizeW'(544);

	// register indexes on the write port
	typedef enum logic [CfgIdxW-1:0] {
		REG_DEADZONE = 3'd0,
		REG_SPEED    = 3'd1,
		REG_ENABLE   = 3'd2,
		REG_WIDTH    = 3'd3,
		REG_HEIGHT   = 3'd4
	} cfg_reg_t;

	// clamp a signed position to [0, min(size - 1, coordinate max)]
	function automatic logic [CoordW-1:0] clamp_coord(input logic [SumW-1:0] pos,
			input logic [SizeW-1:0] size);
		logic [SizeW-1:0]  hi;
		logic [CoordW-1:0] res;
		hi = (size == '0) ? '0 : size - 1'b1;
		if (hi > CoordMax) begin
			hi = CoordMax;
		end
		if (pos[SumW-1]) begin
			res = '0;
		end else if (pos > SumW'(hi)) begin
			res = CoordW'(hi);
		end else begin
			res = pos[CoordW-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* sv/stick_radial_deadzone_cursor.sv */
// stick_radial_deadzone_cursor: bit-serial stick to cursor mover with radial deadzone
// depends on srdc_pkg
//
//  channel  | dir | handshake         | word
//  ---------+-----+-------------------+------------------------------------------------
//  s_       | in  | s_tvalid/s_tready | now_ms, stick_x, stick_y, cursor_x, cursor_y
//  m_       | out | m_tvalid/m_tready | new_x, new_y
//  cfg_     | in  | cfg_we            | cfg_index selects register, cfg_data value
//
// one word at a time: a moving word passes the square, root, check, normalise, scale, step
// divide and output states before the next word is taken; a word inside the deadzone goes
// back to idle from the check, and a word taken with the cursor disabled never leaves idle.
// the work is done by two shift-add lanes and the restoring root and dividers, one bit
// each per cycle, in the order squares, root, deadzone check, normalise, scale, step
// divide, output load.
// reset loads the register defaults and clears the last tick to zero.
// a new word is taken while a result waits in the output register; a finished word
// holds in its last state until that register is free.
`default_nettype none

module stick_radial_deadzone_cursor
	import srdc_pkg::*;
#(
	parameter int MAX_STEP_MS = MaxStepMsDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// slave word, lsb up: now_ms[31:0], stick_x[47:32], stick_y[63:48],
	// cursor_x[75:64], cursor_y[87:76]
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [InW-1:0]      s_tdata,
	// master word, lsb up: new_x[11:0], new_y[23:12]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OutW-1:0]          m_tdata,
	// register writes
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	localparam int DtW = $clog2(MAX_STEP_MS + 1);
	localparam int SdW = SpeedW + DtW;
	localparam int PW  = NW + MagW + SdW;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_SQUARE = 8'b0000_0010,
		ST_ROOT   = 8'b0000_0100,
		ST_CHECK  = 8'b0000_1000,
		ST_NDIV   = 8'b0001_0000,
		ST_MUL    = 8'b0010_0000,
		ST_QDIV   = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [CntW-1:0] cnt_q;

	// registers
	logic [DzW-1:0]    dz_q;
	logic [SpeedW-1:0] speed_q;
	logic              en_q;
	logic [SizeW-1:0]  width_q;
	logic [SizeW-1:0]  height_q;
	logic [TickW-1:0]  last_q;

	// per-word payload
	logic [DtW-1:0]    dt_q;
	logic [MagW-1:0]   mag_q [2];
	logic              neg_q [2];
	logic [CoordW-1:0] cur_q [2];

	// root, normalise and scale registers
	logic [SqW-1:0]  v_q, res_q, bit_q;
	logic [MagW-1:0] m_q;
	logic [SdW-1:0]  sd_q;
	logic [SqW-1:0]  rem_q, den_q;
	logic            sat_q;
	logic [NW-1:0]   n_q;

	// two shift-add / restoring divide lanes, x then y
	logic [PW-1:0] acc_q [2];
	logic [PW-1:0] mc_q  [2];
	logic [NW-1:0] mp_q  [2];

	logic [OutW-1:0] out_q;
	logic            out_valid_q;

	// input word fields
	logic [TickW-1:0]  now_ms;
	logic [AxisW-1:0]  stick [2];
	logic [CoordW-1:0] cursor [2];

	assign now_ms    = s_tdata[31:0];
	assign stick[0]  = s_tdata[47:32];
	assign stick[1]  = s_tdata[63:48];
	assign cursor[0] = s_tdata[75:64];
	assign cursor[1] = s_tdata[87:76];

	logic accept, out_load, last_step;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	assign last_step = (cnt_q == '0);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	// elapsed time, capped
	logic [TickW-1:0] diff;
	logic [DtW-1:0]   dt_cap;
	assign diff   = now_ms - last_q;
	assign dt_cap = (diff > TickW'(MAX_STEP_MS)) ? DtW'(MAX_STEP_MS) : diff[DtW-1:0];

	// absolute axis values
	logic [MagW-1:0] abs_ax [2];
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			abs_ax[i] = stick[i][AxisW-1] ? MagW'(-stick[i]) : stick[i];
		end
	end

	// one root iteration
	logic [SqW-1:0] trial;
	logic           root_ge;
	logic [SqW-1:0] res_next;
	assign trial    = res_q + bit_q;
	assign root_ge  = (v_q >= trial);
	assign res_next = root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// deadzone check and normalise operands
	logic [SqW-1:0] mm, dzs, num, den;
	logic [NW-1:0]  omd;
	logic           in_dz, sat;
	assign mm     = {m_q, 16'b0};
	assign dzs    = {1'b0, dz_q, 15'b0} - SqW'(dz_q);
	assign in_dz  = (mm <= dzs);
	assign num    = mm - dzs;
	assign omd    = NOne - NW'(dz_q);
	assign den    = {omd, 15'b0} - SqW'(omd);
	assign sat    = ({1'b0, num} >= {den, 1'b0});

	// one normalise division step, capped result on the last one
	logic           ndiv_ge;
	logic [SqW-1:0] ndiv_r;
	logic [NW-1:0]  n_next, n_fin;
	assign ndiv_ge = (rem_q >= den_q);
	assign ndiv_r  = ndiv_ge ? (rem_q - den_q) : rem_q;
	assign n_next  = {n_q[NW-2:0], ndiv_ge};
	assign n_fin   = (sat_q || (n_next > NOne)) ? NOne : n_next;

	// magnitude times 1000
	logic [DivW-1:0] dm;
	assign dm = {m_q, 10'b0} - DivW'({m_q, 4'b0}) - DivW'({m_q, 3'b0});

	// lane step logic
	logic [PW-1:0] mul_acc [2];
	logic          qge     [2];
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mul_acc[i] = mp_q[i][0] ? (acc_q[i] + mc_q[i]) : acc_q[i];
			qge[i]     = (acc_q[i] >= mc_q[i]);
		end
	end

	// new positions from the per-axis step
	logic [SumW-1:0]   pos  [2];
	logic [CoordW-1:0] newc [2];
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			pos[i] = neg_q[i] ? (SumW'(cur_q[i]) - SumW'(mp_q[i][QW-1:0]))
			                  : (SumW'(cur_q[i]) + SumW'(mp_q[i][QW-1:0]));
		end
		newc[0] = clamp_coord(pos[0], width_q);
		newc[1] = clamp_coord(pos[1], height_q);
	end

	// control: sequencer, registers, last tick, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			dz_q        <= DzRst;
			speed_q     <= SpeedRst;
			en_q        <= 1'b1;
			width_q     <= WidthRst;
			height_q    <= HeightRst;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEADZONE: dz_q     <= cfg_data[DzW-1:0];
					REG_SPEED:    speed_q  <= cfg_data[SpeedW-1:0];
					REG_ENABLE:   en_q     <= cfg_data[0];
					REG_WIDTH:    width_q  <= cfg_data[SizeW-1:0];
					REG_HEIGHT:   height_q <= cfg_data[SizeW-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				last_q <= now_ms;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (!last_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && en_q) begin
						state_q <= ST_SQUARE;
						cnt_q   <= CntW'(SquareLen - 1);
					end
				end
				ST_SQUARE: begin
					if (last_step) begin
						state_q <= ST_ROOT;
						cnt_q   <= CntW'(RootLen - 1);
					end
				end
				ST_ROOT: begin
					if (last_step) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (in_dz) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_NDIV;
						cnt_q   <= CntW'(NDivLen - 1);
					end
				end
				ST_NDIV: begin
					if (last_step) begin
						state_q <= ST_MUL;
						cnt_q   <= CntW'(MulLen - 1);
					end
				end
				ST_MUL: begin
					if (last_step) begin
						state_q <= ST_QDIV;
						cnt_q   <= CntW'(QDivLen - 1);
					end
				end
				ST_QDIV: begin
					if (last_step) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: lanes, root, normalise divider, payload, output word
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {newc[1], newc[0]};
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					dt_q <= dt_cap;
					for (int i = 0; i < 2; i++) begin
						mag_q[i] <= abs_ax[i];
						neg_q[i] <= stick[i][AxisW-1];
						cur_q[i] <= cursor[i];
						acc_q[i] <= '0;
						mc_q[i]  <= PW'(abs_ax[i]);
						mp_q[i]  <= NW'(abs_ax[i]);
					end
				end
			end
			ST_SQUARE: begin
				for (int i = 0; i < 2; i++) begin
					acc_q[i] <= mul_acc[i];
					mc_q[i]  <= mc_q[i] << 1;
					mp_q[i]  <= mp_q[i] >> 1;
				end
				// sum of squares into the root, speed times time into lane x
				if (last_step) begin
					v_q      <= mul_acc[0][SqW-1:0] + mul_acc[1][SqW-1:0];
					res_q    <= '0;
					bit_q    <= SqW'(1) << (SqW - 2);
					acc_q[0] <= '0;
					mc_q[0]  <= PW'(speed_q);
					mp_q[0]  <= NW'(dt_q);
				end
			end
			ST_ROOT: begin
				if (root_ge) begin
					v_q <= v_q - trial;
				end
				res_q <= res_next;
				bit_q <= bit_q >> 2;
				for (int i = 0; i < 2; i++) begin
					acc_q[i] <= mul_acc[i];
					mc_q[i]  <= mc_q[i] << 1;
					mp_q[i]  <= mp_q[i] >> 1;
				end
				if (last_step) begin
					m_q  <= res_next[MagW-1:0];
					sd_q <= mul_acc[0][SdW-1:0];
				end
			end
			ST_CHECK: begin
				rem_q <= num;
				den_q <= den;
				sat_q <= sat;
				n_q   <= '0;
				for (int i = 0; i < 2; i++) begin
					acc_q[i] <= '0;
					mc_q[i]  <= PW'(sd_q);
					mp_q[i]  <= NW'(mag_q[i]);
				end
			end
			ST_NDIV: begin
				rem_q <= ndiv_r << 1;
				n_q   <= n_next;
				for (int i = 0; i < 2; i++) begin
					acc_q[i] <= mul_acc[i];
					mc_q[i]  <= mc_q[i] << 1;
					mp_q[i]  <= mp_q[i] >> 1;
				end
				// axis times speed times time, now scaled by the normalised magnitude
				if (last_step) begin
					n_q <= n_fin;
					for (int i = 0; i < 2; i++) begin
						acc_q[i] <= '0;
						mc_q[i]  <= mul_acc[i];
						mp_q[i]  <= n_fin;
					end
				end
			end
			ST_MUL: begin
				for (int i = 0; i < 2; i++) begin
					acc_q[i] <= mul_acc[i];
					mc_q[i]  <= mc_q[i] << 1;
					mp_q[i]  <= mp_q[i] >> 1;
				end
				// drop the Q16 fraction, set up the step divide by magnitude times 1000
				if (last_step) begin
					for (int i = 0; i < 2; i++) begin
						acc_q[i] <= mul_acc[i] >> 16;
						mc_q[i]  <= PW'({dm, 11'b0});
						mp_q[i]  <= '0;
					end
				end
			end
			ST_QDIV: begin
				for (int i = 0; i < 2; i++) begin
					if (qge[i]) begin
						acc_q[i] <= acc_q[i] - mc_q[i];
					end
					mc_q[i] <= mc_q[i] >> 1;
					mp_q[i] <= {mp_q[i][NW-2:0], qge[i]};
				end
			end
			ST_OUT: ;
			default: ;
		endcase
	end

`ifndef SYNTH
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && en_q) |=> (state_q == ST_SQUARE))
		else $error("enabled word did not start the square phase");

	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (last_q == $past(now_ms)))
		else $error("last tick not updated on accept");

	a_ncap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (n_q <= NOne))
		else $error("normalised magnitude above one");

	a_rose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && out_valid_q && !m_tready) |=> (state_q == ST_OUT))
		else $error("finished word left while the output register was full");
`endif

endmodule

`default_nettype wire
